FILE: hdl/tsrg_pkg.sv
// ----------------------------------------------------------------------------
// tsrg_pkg: shared types and constants of the speed ramp generator
// Phase codes, microcode word layout, the control store contents and the
// fixed arithmetic constants of the peak search and the frequency coding.
// ----------------------------------------------------------------------------
package tsrg_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HOLD    = 2'd2;

  localparam int BASE_W  = 13;
  localparam int CODE_W  = 8;
  localparam int DIST_W  = 11;
  localparam int MAG_W   = 11;
  localparam int TGT_W   = 20;
  localparam int ACC_W   = 20;
  localparam int INC_W   = 14;

  localparam logic [BASE_W-1:0] BASE_RESET = 13'd400;
  localparam logic [CODE_W-1:0] HOLD_RESET = 8'd30;
  localparam logic [CODE_W-1:0] Y_RESET    = 8'd25;

  // Peak search: target = 1000*|d|, acc grows by 176, 376, 576, ...
  localparam int DIST_SCALE  = 1000;
  localparam int ACC_FIRST   = 176;
  localparam int ACC_GROWTH  = 200;
  localparam int PEAK_BASE   = 50;
  // Upper bound on the peak count for any distance in range.
  localparam int N_MAX       = 80;

  // x = f / 20, saturated at 255, i.e. saturated from 5120 upward.
  localparam int X_SAT_FREQ  = 5120;
  localparam int DIV5_MUL    = 1639;
  localparam int DIV5_SHIFT  = 13;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_UP   = 3'd1,
    PH_DOWN = 3'd2,
    PH_HOLD = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    A_NOP,
    A_ACCEPT,
    A_INIT,
    A_ACC_STEP,
    A_START_DONE,
    A_FORM,
    A_EMIT,
    A_UPDATE
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_CMD_TICK,
    C_PHASE_IDLE,
    C_LOOP_DONE,
    C_OUT_BUSY
  } cond_t;

  localparam int UPC_W = 4;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic             jmp_if;
    logic [UPC_W-1:0] tgt;
  } ucode_t;

  // Status from the datapath that the sequencer branches on.
  typedef struct packed {
    logic cmd_tick;
    logic phase_idle;
    logic loop_done;
    logic out_busy;
  } stat_t;

  // Program addresses.
  localparam logic [UPC_W-1:0] S_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] S_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] S_INIT     = 4'd2;
  localparam logic [UPC_W-1:0] S_LOOP     = 4'd3;
  localparam logic [UPC_W-1:0] S_STEP     = 4'd4;
  localparam logic [UPC_W-1:0] S_FINISH   = 4'd5;
  localparam logic [UPC_W-1:0] S_TICK     = 4'd6;
  localparam logic [UPC_W-1:0] S_FORM     = 4'd7;
  localparam logic [UPC_W-1:0] S_EMIT     = 4'd8;
  localparam logic [UPC_W-1:0] S_UPDATE   = 4'd9;

  // Control store. A word jumps to tgt when its condition equals jmp_if,
  // otherwise it falls through to the next address.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      S_WAIT:     w = '{A_ACCEPT,     C_IN_VALID,   1'b0, S_WAIT};
      S_DISPATCH: w = '{A_NOP,        C_CMD_TICK,   1'b1, S_TICK};
      S_INIT:     w = '{A_INIT,       C_ALWAYS,     1'b0, S_WAIT};
      S_LOOP:     w = '{A_NOP,        C_LOOP_DONE,  1'b1, S_FINISH};
      S_STEP:     w = '{A_ACC_STEP,   C_ALWAYS,     1'b1, S_LOOP};
      S_FINISH:   w = '{A_START_DONE, C_ALWAYS,     1'b1, S_WAIT};
      S_TICK:     w = '{A_NOP,        C_PHASE_IDLE, 1'b1, S_WAIT};
      S_FORM:     w = '{A_FORM,       C_ALWAYS,     1'b0, S_WAIT};
      S_EMIT:     w = '{A_EMIT,       C_OUT_BUSY,   1'b1, S_EMIT};
      S_UPDATE:   w = '{A_UPDATE,     C_ALWAYS,     1'b1, S_WAIT};
      default:    w = '{A_NOP,        C_ALWAYS,     1'b1, S_WAIT};
    endcase
    return w;
  endfunction

  // Frequency below 5120 to code: (f/4)/5 by a reciprocal multiply, exact
  // for f/4 below 1280.
  function automatic logic [CODE_W-1:0] freq_code(input logic [BASE_W-1:0] f);
    logic [20:0] prod;
    prod = 21'(f[BASE_W-1:2]) * 21'(DIV5_MUL);
    return prod[DIV5_SHIFT +: CODE_W];
  endfunction

endpackage

FILE: hdl/tsrg_useq.sv
// ----------------------------------------------------------------------------
// tsrg_useq: microprogram sequencer
// Steps through the control store, branching on datapath status, and hands
// the current word's action to the datapath.
// ----------------------------------------------------------------------------
module tsrg_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tsrg_pkg::stat_t     stat,
  output tsrg_pkg::act_t      act
);

  logic [tsrg_pkg::UPC_W-1:0] upc_r;
  logic [tsrg_pkg::UPC_W-1:0] upc_nxt;
  tsrg_pkg::ucode_t           word;
  logic                       cond_val;

  assign word = tsrg_pkg::ucode_rom(upc_r);
  assign act  = word.act;

  always_comb begin
    unique case (word.cond)
      tsrg_pkg::C_ALWAYS:     cond_val = 1'b1;
      tsrg_pkg::C_IN_VALID:   cond_val = in_valid;
      tsrg_pkg::C_CMD_TICK:   cond_val = stat.cmd_tick;
      tsrg_pkg::C_PHASE_IDLE: cond_val = stat.phase_idle;
      tsrg_pkg::C_LOOP_DONE:  cond_val = stat.loop_done;
      tsrg_pkg::C_OUT_BUSY:   cond_val = stat.out_busy;
      default:                cond_val = 1'b1;
    endcase
    upc_nxt = (cond_val == word.jmp_if) ? word.tgt : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= tsrg_pkg::S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: hdl/tsrg_dp.sv
// ----------------------------------------------------------------------------
// tsrg_dp: ramp datapath
// Configuration registers, the peak search accumulator, the frequency and
// frame counters, the phase register and the output register.
// ----------------------------------------------------------------------------
module tsrg_dp #(
  parameter int FREQ_STEP = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsrg_pkg::act_t                    act,
  output tsrg_pkg::stat_t                   stat,
  input  logic                              in_valid,
  input  logic                              in_command,
  input  logic signed [tsrg_pkg::DIST_W-1:0] in_move_distance,
  input  logic                              cfg_valid,
  input  logic [tsrg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsrg_pkg::BASE_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tsrg_pkg::CODE_W-1:0]       out_x_code,
  output logic [tsrg_pkg::CODE_W-1:0]       out_y_code,
  output logic                              out_direction,
  output logic                              out_last_frame
);

  localparam int FW = $clog2(8192 + tsrg_pkg::PEAK_BASE + FREQ_STEP * (tsrg_pkg::N_MAX + 1));
  localparam logic [FW-1:0] STEP = FW'(FREQ_STEP);
  localparam int CW = tsrg_pkg::CODE_W;

  logic [tsrg_pkg::BASE_W-1:0] base_r;
  logic [CW-1:0]               hold_r;
  logic [CW-1:0]               yhold_r;

  logic                        cmd_r;
  logic [tsrg_pkg::DIST_W-1:0] dist_r;
  logic [tsrg_pkg::TGT_W-1:0]  target_r;
  logic [tsrg_pkg::ACC_W-1:0]  acc_r;
  logic [tsrg_pkg::INC_W-1:0]  inc_r;
  logic [FW-1:0]               peak_r;
  logic [FW-1:0]               cur_r;
  logic [CW-1:0]               frame_r;
  logic                        dir_r;
  tsrg_pkg::phase_t            phase_r;

  logic [CW-1:0]               xs_r;
  logic [CW-1:0]               ys_r;
  logic                        ls_r;
  logic                        out_valid_r;

  logic                        in_fire;
  logic                        out_busy;
  logic [tsrg_pkg::MAG_W-1:0]  mag;
  logic [20:0]                 target_full;
  logic [FW-1:0]               base_ext;
  logic [FW-1:0]               cur_up;
  logic [FW:0]                 down_floor;
  logic [CW-1:0]               frame_inc;
  logic [CW-1:0]               x_ramp;
  tsrg_pkg::phase_t            phase_nxt;

  assign in_fire  = in_valid && (act == tsrg_pkg::A_ACCEPT);
  assign out_busy = out_valid_r && !out_ready;

  assign stat.cmd_tick   = cmd_r;
  assign stat.phase_idle = (phase_r == tsrg_pkg::PH_IDLE);
  assign stat.loop_done  = ({1'b0, target_r} < {acc_r, 1'b0});
  assign stat.out_busy   = out_busy;

  // Two's complement magnitude; the most negative code maps to 1024.
  assign mag = dist_r[tsrg_pkg::DIST_W-1] ? (~dist_r + 1'b1) : dist_r;
  assign target_full = 21'(mag) * 21'(tsrg_pkg::DIST_SCALE);

  assign base_ext   = FW'(base_r);
  assign cur_up     = cur_r + STEP;
  assign down_floor = {1'b0, base_ext} + {1'b0, STEP};
  assign frame_inc  = (frame_r == {CW{1'b1}}) ? frame_r : frame_r + 1'b1;
  assign x_ramp     = (cur_r >= FW'(tsrg_pkg::X_SAT_FREQ)) ? {CW{1'b1}} :
                      tsrg_pkg::freq_code(cur_r[tsrg_pkg::BASE_W-1:0]);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      tsrg_pkg::PH_UP: begin
        if (!(peak_r > cur_up)) phase_nxt = tsrg_pkg::PH_DOWN;
      end
      tsrg_pkg::PH_DOWN: begin
        if (!({1'b0, cur_r} >= down_floor)) begin
          phase_nxt = (frame_inc < hold_r) ? tsrg_pkg::PH_HOLD : tsrg_pkg::PH_STOP;
        end
      end
      tsrg_pkg::PH_HOLD: begin
        if (frame_inc >= hold_r) phase_nxt = tsrg_pkg::PH_STOP;
      end
      tsrg_pkg::PH_STOP: phase_nxt = tsrg_pkg::PH_IDLE;
      default:           phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= tsrg_pkg::BASE_RESET;
      hold_r  <= tsrg_pkg::HOLD_RESET;
      yhold_r <= tsrg_pkg::Y_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsrg_pkg::REG_BASE_FREQ: base_r  <= cfg_data;
        tsrg_pkg::REG_HOLD:      hold_r  <= cfg_data[CW-1:0];
        tsrg_pkg::REG_Y_HOLD:    yhold_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tsrg_pkg::PH_IDLE;
      cur_r       <= '0;
      peak_r      <= '0;
      frame_r     <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (act)
        tsrg_pkg::A_INIT: begin
          // The first accumulator step always runs, so it is folded in here.
          peak_r <= FW'(tsrg_pkg::PEAK_BASE);
        end
        tsrg_pkg::A_ACC_STEP: begin
          peak_r <= peak_r + STEP;
        end
        tsrg_pkg::A_START_DONE: begin
          dir_r   <= (dist_r != '0) && !dist_r[tsrg_pkg::DIST_W-1];
          cur_r   <= base_ext;
          frame_r <= '0;
          phase_r <= (peak_r > base_ext) ? tsrg_pkg::PH_UP : tsrg_pkg::PH_DOWN;
        end
        tsrg_pkg::A_EMIT: begin
          if (!out_busy) out_valid_r <= 1'b1;
        end
        tsrg_pkg::A_UPDATE: begin
          phase_r <= phase_nxt;
          if (phase_r != tsrg_pkg::PH_STOP) frame_r <= frame_inc;
          if (phase_r == tsrg_pkg::PH_UP) begin
            cur_r <= cur_up;
          end else if (phase_r == tsrg_pkg::PH_DOWN && {1'b0, cur_r} >= down_floor) begin
            cur_r <= cur_r - STEP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_command;
      dist_r <= in_move_distance;
    end
    case (act)
      tsrg_pkg::A_INIT: begin
        target_r <= target_full[tsrg_pkg::TGT_W-1:0];
        acc_r    <= tsrg_pkg::ACC_W'(tsrg_pkg::ACC_FIRST);
        inc_r    <= tsrg_pkg::INC_W'(tsrg_pkg::ACC_FIRST + tsrg_pkg::ACC_GROWTH);
      end
      tsrg_pkg::A_ACC_STEP: begin
        acc_r <= acc_r + tsrg_pkg::ACC_W'(inc_r);
        inc_r <= inc_r + tsrg_pkg::INC_W'(tsrg_pkg::ACC_GROWTH);
      end
      tsrg_pkg::A_FORM: begin
        case (phase_r) inside
          tsrg_pkg::PH_UP, tsrg_pkg::PH_DOWN: begin
            xs_r <= x_ramp;
            ys_r <= yhold_r;
            ls_r <= 1'b0;
          end
          tsrg_pkg::PH_HOLD: begin
            xs_r <= '0;
            ys_r <= yhold_r;
            ls_r <= 1'b0;
          end
          default: begin
            xs_r <= '0;
            ys_r <= '0;
            ls_r <= 1'b1;
          end
        endcase
      end
      tsrg_pkg::A_EMIT: begin
        if (!out_busy) begin
          out_x_code     <= xs_r;
          out_y_code     <= ys_r;
          out_last_frame <= ls_r;
          out_direction  <= dir_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/triangular_speed_ramp_generator.sv
// ----------------------------------------------------------------------------
// triangular_speed_ramp_generator: triangular motor speed ramp
// A start item finds the ramp peak from the move distance; each tick item
// then yields one frame of the up ramp, down ramp, hold and stop sequence.
// ----------------------------------------------------------------------------
// Start item: the accumulator compare/add loop of the microprogram finds the peak
// count n (at most 72); it yields no result.
// Tick item while a move runs: the frame is formed, emitted to the output register
// once that is free, then the phase is updated; a tick while idle yields nothing.
// Synchronous active-low reset: phase idle, counters cleared, output empty,
// registers at base 400, hold 30, y code 25. No clearing pass.
module triangular_speed_ramp_generator #(
  parameter int FREQ_STEP = 100
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [tsrg_pkg::DIST_W-1:0] in_move_distance,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tsrg_pkg::CODE_W-1:0]        out_x_code,
  output logic [tsrg_pkg::CODE_W-1:0]        out_y_code,
  output logic                               out_direction,
  output logic                               out_last_frame,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsrg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsrg_pkg::BASE_W-1:0]        cfg_data
);

  tsrg_pkg::act_t  act;
  tsrg_pkg::stat_t stat;

  assign in_ready  = (act == tsrg_pkg::A_ACCEPT);
  assign cfg_ready = 1'b1;

  tsrg_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .act      (act)
  );

  tsrg_dp #(
    .FREQ_STEP (FREQ_STEP)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .act              (act),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_command       (in_command),
    .in_move_distance (in_move_distance),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_code       (out_x_code),
    .out_y_code       (out_y_code),
    .out_direction    (out_direction),
    .out_last_frame   (out_last_frame)
  );

endmodule

FILE: hdl/tsrg_checker.sv
// ----------------------------------------------------------------------------
// tsrg_checker: port-level checks of the speed ramp generator
// Watches the top level's ports and flags reset, sequencing and frame
// coding slips.
// ----------------------------------------------------------------------------
module tsrg_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tsrg_pkg::CODE_W-1:0]        out_x_code,
  input logic [tsrg_pkg::CODE_W-1:0]        out_y_code,
  input logic                               out_last_frame
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // After taking an item the sequencer is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // The stop frame carries zero codes on both axes.
  a_stop_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_frame |-> out_x_code == '0 && out_y_code == '0)
    else $error("stop frame with nonzero codes");

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_code) &&
      $stable(out_y_code) && $stable(out_last_frame))
    else $error("stalled output item changed");

endmodule

bind triangular_speed_ramp_generator tsrg_checker u_tsrg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_x_code     (out_x_code),
  .out_y_code     (out_y_code),
  .out_last_frame (out_last_frame)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the triangular speed ramp generator
// A ramp tracker mirrors the peak search and the up, down, hold and stop
// sequence of every move. Each frame the block sends is compared with the
// oldest predicted one while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREQ_STEP = 100;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Peak search and frequency coding.
  localparam int unsigned DIST_MILLI  = 1000;
  localparam int unsigned ACC_STEP0   = 176;
  localparam int unsigned ACC_GROW    = 200;
  localparam int unsigned PEAK_OFFSET = 50;
  localparam int unsigned SEARCH_CAP  = 200;
  localparam int unsigned X_DIV       = 20;
  localparam int unsigned X_MAX       = 255;

  // A start item may keep the block busy in its peak search without a frame.
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [tsrg_pkg::CODE_W-1:0] x_code;
    logic [tsrg_pkg::CODE_W-1:0] y_code;
    logic                        direction;
    logic                        last_frame;
  } frame_t;

  class ramp_tracker;
    logic [tsrg_pkg::BASE_W-1:0] base_freq;
    logic [tsrg_pkg::CODE_W-1:0] hold_frames;
    logic [tsrg_pkg::CODE_W-1:0] y_hold;
    tsrg_pkg::phase_t            phase;
    int unsigned                 cur_freq;
    int unsigned                 peak_freq;
    logic [7:0]                  frames_out;
    logic                        dir;
    frame_t                      due_frames[$];
    int starts, ticks, moving_items, frames_checked, failures;

    function new();
      base_freq   = 13'd400;
      hold_frames = 8'd30;
      y_hold      = 8'd25;
      phase       = tsrg_pkg::PH_IDLE;
      cur_freq    = 0;
      peak_freq   = 0;
      frames_out  = '0;
      dir         = 1'b0;
    endfunction

    function void set_reg(logic [tsrg_pkg::CFG_IDX_W-1:0] idx,
                          logic [tsrg_pkg::BASE_W-1:0] data);
      case (idx)
        tsrg_pkg::REG_BASE_FREQ: base_freq = data;
        tsrg_pkg::REG_HOLD:      hold_frames = data[tsrg_pkg::CODE_W-1:0];
        tsrg_pkg::REG_Y_HOLD:    y_hold = data[tsrg_pkg::CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [tsrg_pkg::CODE_W-1:0] freq_to_x(int unsigned f);
      int unsigned q;
      q = f / X_DIV;
      return (q > X_MAX) ? tsrg_pkg::CODE_W'(X_MAX) : tsrg_pkg::CODE_W'(q);
    endfunction

    function void push_frame(logic [tsrg_pkg::CODE_W-1:0] x,
                             logic [tsrg_pkg::CODE_W-1:0] y, logic last);
      frame_t f;
      f = '{x, y, dir, last};
      due_frames.push_back(f);
    endfunction

    function void count_frame();
      if (frames_out != 8'hFF) frames_out++;
    endfunction

    function void note_item(logic cmd, logic signed [tsrg_pkg::DIST_W-1:0] distance);
      int sd;
      int unsigned mag, target, acc, n;
      if (cmd == CMD_START) begin
        starts++;
        moving_items++;
        sd = distance;
        mag = (sd < 0) ? -sd : sd;
        target = DIST_MILLI * mag;
        acc = 0;
        n = 0;
        while (target >= 2 * acc && n < SEARCH_CAP) begin
          acc += ACC_STEP0 + ACC_GROW * n;
          n++;
        end
        dir        = (sd > 0);
        peak_freq  = PEAK_OFFSET + FREQ_STEP * (n - 1);
        cur_freq   = 32'(base_freq);
        frames_out = '0;
        phase      = (peak_freq > cur_freq) ? tsrg_pkg::PH_UP : tsrg_pkg::PH_DOWN;
        return;
      end
      ticks++;
      if (phase != tsrg_pkg::PH_IDLE) moving_items++;
      case (phase)
        tsrg_pkg::PH_UP: begin
          push_frame(freq_to_x(cur_freq), y_hold, 1'b0);
          count_frame();
          cur_freq += FREQ_STEP;
          if (!(peak_freq > cur_freq)) phase = tsrg_pkg::PH_DOWN;
        end
        tsrg_pkg::PH_DOWN: begin
          push_frame(freq_to_x(cur_freq), y_hold, 1'b0);
          count_frame();
          if (cur_freq >= FREQ_STEP && cur_freq - FREQ_STEP >= base_freq)
            cur_freq -= FREQ_STEP;
          else
            phase = (frames_out < hold_frames) ? tsrg_pkg::PH_HOLD : tsrg_pkg::PH_STOP;
        end
        tsrg_pkg::PH_HOLD: begin
          push_frame('0, y_hold, 1'b0);
          count_frame();
          if (frames_out >= hold_frames) phase = tsrg_pkg::PH_STOP;
        end
        tsrg_pkg::PH_STOP: begin
          push_frame('0, '0, 1'b1);
          phase = tsrg_pkg::PH_IDLE;
        end
        default: ;
      endcase
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (due_frames.size() == 0) begin
        $error("frame with nothing pending: x_code %0d y_code %0d direction %0d last_frame %0d",
               got.x_code, got.y_code, got.direction, got.last_frame);
        failures++;
        return;
      end
      want = due_frames.pop_front();
      frames_checked++;
      if (got.x_code !== want.x_code) begin
        $error("x_code: expected %0d, got %0d", want.x_code, got.x_code);
        failures++;
      end
      if (got.y_code !== want.y_code) begin
        $error("y_code: expected %0d, got %0d", want.y_code, got.y_code);
        failures++;
      end
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, got %0d", want.direction, got.direction);
        failures++;
      end
      if (got.last_frame !== want.last_frame) begin
        $error("last_frame: expected %0d, got %0d", want.last_frame, got.last_frame);
        failures++;
      end
    endfunction

    function bit moving();
      return phase != tsrg_pkg::PH_IDLE;
    endfunction

    function int pending();
      return due_frames.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_command = CMD_TICK;
  logic signed [tsrg_pkg::DIST_W-1:0] in_move_distance = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [tsrg_pkg::CODE_W-1:0]        out_x_code;
  logic [tsrg_pkg::CODE_W-1:0]        out_y_code;
  logic                               out_direction;
  logic                               out_last_frame;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [tsrg_pkg::CFG_IDX_W-1:0]     cfg_index = tsrg_pkg::REG_BASE_FREQ;
  logic [tsrg_pkg::BASE_W-1:0]        cfg_data = '0;

  ramp_tracker ramp;
  int          burst_left = 0;
  int          settings = 1;
  int          idle_cycles = 0;
  logic [9:0]  stall_cyc = '0;

  triangular_speed_ramp_generator #(
    .FREQ_STEP(FREQ_STEP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_move_distance (in_move_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_code       (out_x_code),
    .out_y_code       (out_y_code),
    .out_direction    (out_direction),
    .out_last_frame   (out_last_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver cycles through always ready, coin flips, a sparse fixed
  // pattern and long random stalls.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready <= (stall_cyc[2:0] == 3'd5);
      default: out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ramp.check_frame('{out_x_code, out_y_code, out_direction, out_last_frame});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Run stalled for %0d cycles with %0d frames pending.",
                 STALL_LIMIT, ramp.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic signed [tsrg_pkg::DIST_W-1:0] pick_distance();
    int mag, sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) mag = $urandom_range(0, 60);
    else if (sel < 95) mag = $urandom_range(0, 1000);
    else mag = (sel < 98) ? 1000 : 0;
    return tsrg_pkg::DIST_W'(($urandom_range(0, 1) == 1) ? -mag : mag);
  endfunction

  // The sender works in bursts; a new burst starts after a random gap.
  task automatic send_item(input logic cmd,
                           input logic signed [tsrg_pkg::DIST_W-1:0] distance);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_move_distance <= distance;
    do @(posedge clk); while (!in_ready);
    ramp.note_item(cmd, distance);
  endtask

  task automatic run_move(input logic signed [tsrg_pkg::DIST_W-1:0] distance);
    int guard;
    guard = 0;
    send_item(CMD_START, distance);
    while (ramp.moving() && guard < 400) begin
      send_item(CMD_TICK, pick_distance());
      guard++;
    end
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      run_move(pick_distance());
    end else if (pick < 85) begin
      // A move cut short by the next start.
      send_item(CMD_START, pick_distance());
      repeat ($urandom_range(0, 8)) send_item(CMD_TICK, pick_distance());
    end else begin
      send_item(logic'($urandom_range(0, 1)), pick_distance());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ramp.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [tsrg_pkg::BASE_W-1:0] base,
                              input logic [tsrg_pkg::CODE_W-1:0] hold,
                              input logic [tsrg_pkg::CODE_W-1:0] ycode);
    logic [tsrg_pkg::CFG_IDX_W-1:0] idx [3];
    logic [tsrg_pkg::BASE_W-1:0]    val [3];
    idx = '{tsrg_pkg::REG_BASE_FREQ, tsrg_pkg::REG_HOLD, tsrg_pkg::REG_Y_HOLD};
    val = '{base, tsrg_pkg::BASE_W'(hold), tsrg_pkg::BASE_W'(ycode)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      ramp.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int goal;
    ramp = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed part at the reset settings: a tick while idle, the
    // distance extremes, starts that abandon a running move and a base
    // above the peak.
    send_item(CMD_TICK, 11'sd0);
    send_item(CMD_START, 11'sd0);
    send_item(CMD_TICK, 11'sd0);
    send_item(CMD_TICK, -11'sd1);
    send_item(CMD_START, -11'sd1000);
    repeat (3) send_item(CMD_TICK, 11'sd1000);
    send_item(CMD_START, 11'sd1000);
    repeat (2) send_item(CMD_TICK, -11'sd1000);
    send_item(CMD_START, 11'sd1);
    send_item(CMD_START, -11'sd1);
    repeat (2) send_item(CMD_TICK, 11'sd0);
    send_item(CMD_START, 11'sd15);
    repeat (3) send_item(CMD_TICK, 11'sd0);
    drain();

    // Longest move: ramp down to a zero base, saturated codes, hold padded to 255.
    program_regs(13'd0, 8'd255, 8'd255);
    run_move(11'sd1000);
    drain();

    // Highest base, no hold frames.
    program_regs(13'd5000, 8'd0, 8'd0);
    run_move(-11'sd1000);
    run_move(11'sd3);
    run_move(11'sd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      program_regs(($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 1500))
                                              : 13'($urandom_range(0, 5000)),
                   ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 60)),
                   8'($urandom_range(0, 255)));
      goal = ramp.moving_items + PHASE_ITEMS;
      while (ramp.moving_items < goal) random_sequence();
      drain();
    end

    $display("Sent %0d start and %0d tick items under %0d register settings.",
             ramp.starts, ramp.ticks, settings);
    $display("Checked %0d frames; %0d mismatches.", ramp.frames_checked, ramp.failures);
    if (ramp.failures == 0 && ramp.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
